[rtl/usg_pkg.sv]
// Shared types, constants and arithmetic helpers for the UV sphere generator.
`default_nettype none

package usg_pkg;

  localparam int MAX_STACKS = 32;
  localparam int MAX_SLICES = 1024;
  localparam int DIV_W      = 43;
  localparam int DVSR_W     = 11;
  localparam int NDIV       = 11;
  localparam int Q_DEPTH    = 2;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // floor(v / d) == (v * M) >> SH for every v < 2^30 with M = ceil(2^SH / d)
  localparam logic [31:0] RECIP_M [NDIV] = '{
    32'(((64'd1 << 37) + 64'd109) / 64'd110),
    32'(((64'd1 << 37) + 64'd71)  / 64'd72),
    32'(((64'd1 << 36) + 64'd41)  / 64'd42),
    32'(((64'd1 << 35) + 64'd19)  / 64'd20),
    32'(((64'd1 << 33) + 64'd5)   / 64'd6),
    32'(((64'd1 << 38) + 64'd131) / 64'd132),
    32'(((64'd1 << 37) + 64'd89)  / 64'd90),
    32'(((64'd1 << 36) + 64'd55)  / 64'd56),
    32'(((64'd1 << 35) + 64'd29)  / 64'd30),
    32'(((64'd1 << 34) + 64'd11)  / 64'd12),
    32'(((64'd1 << 31) + 64'd1)   / 64'd2)
  };
  localparam logic [5:0] RECIP_SH [NDIV] = '{
    6'd37, 6'd37, 6'd36, 6'd35, 6'd33, 6'd38, 6'd37, 6'd36, 6'd35, 6'd34, 6'd31
  };
  localparam logic [3:0] SIN_LAST = 4'd4;
  localparam logic [3:0] COS_LAST = 4'd10;

  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_SLICES = 3'd1;
  localparam logic [2:0] REG_STACKS = 3'd2;
  localparam logic [2:0] REG_CX     = 3'd3;
  localparam logic [2:0] REG_CY     = 3'd4;
  localparam logic [2:0] REG_CZ     = 3'd5;
  localparam logic [2:0] REG_IBASE  = 3'd6;

  typedef struct packed {
    logic [30:0]        radius;
    logic [10:0]        slices;      // clamped to 1..MAX_SLICES
    logic [5:0]         stacks;      // clamped to 2..MAX_STACKS
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [23:0]        index_base;
  } usg_cfg_t;

  function automatic logic [10:0] clamp_slices(input logic [10:0] v);
    logic [10:0] r;
    r = v;
    if (v == 11'd0) r = 11'd1;
    else if (v > 11'(MAX_SLICES)) r = 11'(MAX_SLICES);
    return r;
  endfunction

  function automatic logic [5:0] clamp_stacks(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (v < 6'd2) r = 6'd2;
    else if (v > 6'(MAX_STACKS)) r = 6'(MAX_STACKS);
    return r;
  endfunction

  // shift right by 30, magnitude rounded half up
  function automatic logic signed [33:0] rnd30(input logic signed [65:0] v);
    logic [65:0] mag;
    logic [65:0] rs;
    mag = v[65] ? 66'(-v) : 66'(v);
    rs  = (mag + (66'd1 << 29)) >> 30;
    return v[65] ? -$signed(rs[33:0]) : $signed(rs[33:0]);
  endfunction

  function automatic logic [15:0] rnd16(input logic signed [31:0] v);
    logic [31:0] mag;
    logic [31:0] rs;
    mag = v[31] ? 32'(-v) : 32'(v);
    rs  = (mag + 32'h0000_8000) >> 16;
    return v[31] ? 16'(-rs) : rs[15:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) r = v[31:0];
    else if (v[34]) r = 32'h8000_0000;
    else r = 32'h7FFF_FFFF;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/usg_fifo.sv]
// Two-entry queue of slice numbers between the front end and the sequencer.
`default_nettype none

module usg_fifo
  import usg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [9:0] wdata,
  input  logic       pop,
  output logic [9:0] rdata,
  output logic       not_empty,
  output logic       full
);

  logic [9:0] mem [Q_DEPTH];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign not_empty = (count_r != 2'd0);
  assign full      = (count_r == 2'(Q_DEPTH));
  assign rdata     = mem[rptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr_r] <= wdata;
  end

endmodule

`default_nettype wire

[rtl/usg_front.sv]
// Input stage: takes slice requests and drops those outside the slice count.
`default_nettype none

module usg_front
  import usg_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [9:0] in_slice_number,
  input  logic [10:0] slices,
  input  logic       q_full,
  output logic       q_push,
  output logic [9:0] q_data
);

  logic in_range;

  assign in_ready = !q_full;
  assign in_range = ({1'b0, in_slice_number} < slices);
  assign q_push   = in_valid && in_ready && in_range;
  assign q_data   = in_slice_number;

endmodule

`default_nettype wire

[rtl/usg_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module usg_div
  import usg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DVSR_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient
);

  logic [DVSR_W-1:0] rem_r;
  logic [DVSR_W-1:0] dsr_r;
  logic [DIV_W-1:0]  quo_r;
  logic [5:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DVSR_W:0]   trial;
  logic [DVSR_W:0]   diff;
  logic              take;

  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign take     = (trial >= {1'b0, dsr_r});
  assign diff     = trial - {1'b0, dsr_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

[rtl/usg_back.sv]
// Slice sequencer: phases, sin/cos polynomials, vertex math and result register.
`default_nettype none

module usg_back
  import usg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  usg_cfg_t    cfg,
  input  logic        q_valid,
  input  logic [9:0]  q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_pos_z,
  output logic [15:0] out_norm_x,
  output logic [15:0] out_norm_y,
  output logic [15:0] out_norm_z,
  output logic        out_tri_valid,
  output logic [23:0] out_tri_a,
  output logic [23:0] out_tri_b,
  output logic [23:0] out_tri_c,
  output logic        out_last
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DIV0  = 5'd1;
  localparam logic [4:0] ST_DIV1  = 5'd2;
  localparam logic [4:0] ST_DIVL  = 5'd3;
  localparam logic [4:0] ST_SCX   = 5'd4;
  localparam logic [4:0] ST_SCXR  = 5'd5;
  localparam logic [4:0] ST_SCSQ  = 5'd6;
  localparam logic [4:0] ST_SCSQR = 5'd7;
  localparam logic [4:0] ST_TA    = 5'd8;
  localparam logic [4:0] ST_TC    = 5'd9;
  localparam logic [4:0] ST_TD    = 5'd10;
  localparam logic [4:0] ST_SA    = 5'd11;
  localparam logic [4:0] ST_SB    = 5'd12;
  localparam logic [4:0] ST_FIN   = 5'd13;
  localparam logic [4:0] ST_LMX   = 5'd14;
  localparam logic [4:0] ST_LRX   = 5'd15;
  localparam logic [4:0] ST_LRZ   = 5'd16;
  localparam logic [4:0] ST_VMX   = 5'd17;
  localparam logic [4:0] ST_VRX   = 5'd18;
  localparam logic [4:0] ST_VRY   = 5'd19;
  localparam logic [4:0] ST_VRZ   = 5'd20;
  localparam logic [4:0] ST_VEMIT = 5'd21;

  localparam logic [1:0] RET_LON0 = 2'd0;
  localparam logic [1:0] RET_LON1 = 2'd1;
  localparam logic [1:0] RET_LAT  = 2'd2;

  logic [4:0]  state_r, state_nxt;
  logic [9:0]  i_r;
  logic [5:0]  j_r;
  logic [6:0]  k_r;
  logic [1:0]  ret_r;
  logic [3:0]  cnt_r;
  logic [23:0] base_r;
  logic [23:0] vc_r;
  logic [31:0] ph_r;
  logic [29:0] x_r;
  logic [29:0] x2_r;
  logic [30:0] t_r;
  logic [30:0] ps_r;
  logic signed [31:0] s0_r, c0_r, s1_r, c1_r, sl_r, cl_r;
  logic signed [31:0] nx_r, ny_r, nz_r;
  logic [31:0] px_r, py_r, pz_r;
  logic signed [65:0] prod_r;

  logic        out_valid_r;
  logic [31:0] out_pos_x_r, out_pos_y_r, out_pos_z_r;
  logic [15:0] out_norm_x_r, out_norm_y_r, out_norm_z_r;
  logic        out_tri_valid_r;
  logic [23:0] out_tri_a_r, out_tri_b_r, out_tri_c_r;
  logic        out_last_r;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DVSR_W-1:0] div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_quotient;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [65:0]        prod_u;
  logic [65:0]        xr_sum, x2_sum, td_shift;
  logic signed [33:0] prod_rnd;
  logic signed [31:0] ctr;
  logic signed [34:0] pos_sum;
  logic [29:0]        f_w;
  logic               fold;
  logic [30:0]        fm_full;
  logic [29:0]        fm;
  logic [30:0]        sa_u, ca_u;
  logic signed [31:0] sa, ca, s_f, c_f;
  logic [6:0]         nres;
  logic [6:0]         k_inc;
  logic [5:0]         j_inc;
  logic               slot;
  logic               emit;
  logic [23:0]        bk;
  logic signed [31:0] neg_one;

  usg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign nres    = {cfg.stacks, 1'b0};
  assign k_inc   = k_r + 7'd1;
  assign j_inc   = j_r + 6'd1;
  assign slot    = !out_valid_r || out_ready;
  assign neg_one = -$signed({1'b0, Q30_ONE});

  // phase folding to the first octant
  assign f_w     = ph_r[29:0];
  assign fold    = (f_w > 30'h2000_0000);
  assign fm_full = 31'h4000_0000 - {1'b0, f_w};
  assign fm      = fold ? fm_full[29:0] : f_w;

  assign sa_u = fold ? t_r : ps_r;
  assign ca_u = fold ? ps_r : t_r;
  assign sa   = $signed({1'b0, sa_u});
  assign ca   = $signed({1'b0, ca_u});

  always_comb begin
    case (ph_r[31:30])
      2'd0:    begin s_f = sa;  c_f = ca;  end
      2'd1:    begin s_f = ca;  c_f = -sa; end
      2'd2:    begin s_f = -sa; c_f = -ca; end
      default: begin s_f = -ca; c_f = sa;  end
    endcase
  end

  // shared multiplier, always registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SCX:  begin mul_a = $signed({3'b0, fm});   mul_b = $signed({1'b0, PI_Q30}); end
      ST_SCSQ: begin mul_a = $signed({3'b0, x_r});  mul_b = $signed({3'b0, x_r}); end
      ST_TA:   begin mul_a = $signed({3'b0, x2_r}); mul_b = $signed({2'b0, t_r}); end
      ST_TC:   begin
        mul_a = $signed({3'b0, prod_r[59:30]});
        mul_b = $signed({1'b0, RECIP_M[cnt_r]});
      end
      ST_SA:   begin mul_a = $signed({3'b0, x_r});  mul_b = $signed({2'b0, t_r}); end
      ST_LMX:  begin
        mul_a = {sl_r[31], sl_r};
        mul_b = k_r[0] ? {s0_r[31], s0_r} : {s1_r[31], s1_r};
      end
      ST_LRX:  begin
        mul_a = {sl_r[31], sl_r};
        mul_b = k_r[0] ? {c0_r[31], c0_r} : {c1_r[31], c1_r};
      end
      ST_VMX:  begin mul_a = $signed({2'b0, cfg.radius}); mul_b = {nx_r[31], nx_r}; end
      ST_VRX:  begin mul_a = $signed({2'b0, cfg.radius}); mul_b = {ny_r[31], ny_r}; end
      ST_VRY:  begin mul_a = $signed({2'b0, cfg.radius}); mul_b = {nz_r[31], nz_r}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_u   = $unsigned(prod_r);
  assign xr_sum   = prod_u + (66'd1 << 30);
  assign x2_sum   = prod_u + (66'd1 << 29);
  assign td_shift = prod_u >> RECIP_SH[cnt_r];
  assign prod_rnd = rnd30(prod_r);

  always_comb begin
    case (state_r)
      ST_VRX:  ctr = cfg.cx;
      ST_VRY:  ctr = cfg.cy;
      default: ctr = cfg.cz;
    endcase
  end
  assign pos_sum = $signed({{3{ctr[31]}}, ctr}) + $signed({prod_rnd[33], prod_rnd});

  assign bk = base_r + 24'(k_r);

  always_comb begin
    state_nxt    = state_r;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = cfg.slices;
    emit         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          div_start    = 1'b1;
          div_dividend = {1'b0, q_data, 32'b0};
          state_nxt    = ST_DIV0;
        end
      end
      ST_DIV0, ST_DIV1, ST_DIVL: begin
        if (div_done) state_nxt = ST_SCX;
      end
      ST_SCX:   state_nxt = ST_SCXR;
      ST_SCXR:  state_nxt = ST_SCSQ;
      ST_SCSQ:  state_nxt = ST_SCSQR;
      ST_SCSQR: state_nxt = ST_TA;
      ST_TA:    state_nxt = ST_TC;
      ST_TC:    state_nxt = ST_TD;
      ST_TD: begin
        if (cnt_r == SIN_LAST) state_nxt = ST_SA;
        else if (cnt_r == COS_LAST) state_nxt = ST_FIN;
        else state_nxt = ST_TA;
      end
      ST_SA: state_nxt = ST_SB;
      ST_SB: state_nxt = ST_TA;
      ST_FIN: begin
        case (ret_r)
          RET_LON0: begin
            div_start    = 1'b1;
            div_dividend = {11'({1'b0, i_r}) + 11'd1, 32'b0};
            state_nxt    = ST_DIV1;
          end
          RET_LON1: state_nxt = ST_VMX;
          default:  state_nxt = ST_LMX;
        endcase
      end
      ST_LMX: state_nxt = ST_LRX;
      ST_LRX: state_nxt = ST_LRZ;
      ST_LRZ: state_nxt = ST_VMX;
      ST_VMX: state_nxt = ST_VRX;
      ST_VRX: state_nxt = ST_VRY;
      ST_VRY: state_nxt = ST_VRZ;
      ST_VRZ: state_nxt = ST_VEMIT;
      ST_VEMIT: begin
        if (slot) begin
          emit = 1'b1;
          if (k_inc == nres) begin
            state_nxt = ST_IDLE;
          end else if (k_inc == nres - 7'd1) begin
            state_nxt = ST_VMX;
          end else if (k_inc[0]) begin
            // next latitude ring
            div_start    = 1'b1;
            div_dividend = {6'b0, j_inc, 31'b0};
            div_divisor  = {5'b0, cfg.stacks};
            state_nxt    = ST_DIVL;
          end else begin
            state_nxt = ST_LMX;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= 7'd0;
      j_r         <= 6'd0;
      ret_r       <= RET_LON0;
      cnt_r       <= 4'd0;
      vc_r        <= 24'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        k_r <= 7'd0;
        j_r <= 6'd0;
      end
      case (state_r)
        ST_DIV0:  if (div_done) ret_r <= RET_LON0;
        ST_DIV1:  if (div_done) ret_r <= RET_LON1;
        ST_DIVL:  if (div_done) ret_r <= RET_LAT;
        ST_SCSQR: cnt_r <= 4'd0;
        ST_TD:    cnt_r <= cnt_r + 4'd1;
        default:  ;
      endcase
      if (emit) begin
        k_r <= k_inc;
        if (k_inc[0] && k_inc != nres - 7'd1) j_r <= j_inc;
        if (k_inc == nres) vc_r <= vc_r + 24'(nres);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          i_r    <= q_data;
          base_r <= cfg.index_base + vc_r;
        end
      end
      ST_DIV0, ST_DIV1, ST_DIVL: begin
        if (div_done) ph_r <= div_quotient[31:0];
      end
      ST_SCXR: x_r <= xr_sum[60:31];
      ST_SCSQR: begin
        x2_r <= x2_sum[59:30];
        t_r  <= Q30_ONE;
      end
      ST_TD: t_r <= Q30_ONE - td_shift[30:0];
      ST_SB: begin
        ps_r <= prod_u[60:30];
        t_r  <= Q30_ONE;
      end
      ST_FIN: begin
        case (ret_r)
          RET_LON0: begin s0_r <= s_f; c0_r <= c_f; end
          RET_LON1: begin
            s1_r <= s_f;
            c1_r <= c_f;
            nx_r <= '0;
            ny_r <= neg_one;
            nz_r <= '0;
          end
          default: begin sl_r <= s_f; cl_r <= c_f; end
        endcase
      end
      ST_LRX: nx_r <= prod_rnd[31:0];
      ST_LRZ: begin
        nz_r <= prod_rnd[31:0];
        ny_r <= -cl_r;
      end
      ST_VRX: px_r <= sat32(pos_sum);
      ST_VRY: py_r <= sat32(pos_sum);
      ST_VRZ: pz_r <= sat32(pos_sum);
      ST_VEMIT: begin
        if (slot && k_inc == nres - 7'd1) begin
          // top pole
          nx_r <= '0;
          ny_r <= $signed({1'b0, Q30_ONE});
          nz_r <= '0;
        end
      end
      default: ;
    endcase
    if (emit) begin
      out_pos_x_r     <= px_r;
      out_pos_y_r     <= py_r;
      out_pos_z_r     <= pz_r;
      out_norm_x_r    <= rnd16(nx_r);
      out_norm_y_r    <= rnd16(ny_r);
      out_norm_z_r    <= rnd16(nz_r);
      out_last_r      <= (k_inc == nres);
      out_tri_valid_r <= (k_r >= 7'd2);
      if (k_r < 7'd2) begin
        out_tri_a_r <= '0;
        out_tri_b_r <= '0;
        out_tri_c_r <= '0;
      end else begin
        out_tri_a_r <= bk - 24'd2;
        out_tri_b_r <= k_r[0] ? bk - 24'd1 : bk;
        out_tri_c_r <= k_r[0] ? bk : bk - 24'd1;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pos_x     = out_pos_x_r;
  assign out_pos_y     = out_pos_y_r;
  assign out_pos_z     = out_pos_z_r;
  assign out_norm_x    = out_norm_x_r;
  assign out_norm_y    = out_norm_y_r;
  assign out_norm_z    = out_norm_z_r;
  assign out_tri_valid = out_tri_valid_r;
  assign out_tri_a     = out_tri_a_r;
  assign out_tri_b     = out_tri_b_r;
  assign out_tri_c     = out_tri_c_r;
  assign out_last      = out_last_r;

  a_last_has_tri: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_tri_valid_r)
    else $error("last transaction of a slice carries no triangle");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_norm_y_r) <= 16'sd16384 &&
                     $signed(out_norm_y_r) >= -16'sd16384))
    else $error("normal component out of unit range");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> k_r < nres)
    else $error("result counter ran past the slice");

endmodule

`default_nettype wire

[rtl/uv_sphere_mesh_generator_top.sv]
// UV sphere generator: slices in, vertices with triangles out; config regs over APB.
// Each slice gives 2*S results (S = clamped stack count).
// Per ring the 43-step restoring divider and the shared multiplier (eleven polynomial terms
// per sin/cos pair) set the time; one slice is worked at a time.
// Synchronous active-low reset loads register defaults and clears the vertex counter.
`default_nettype none

module uv_sphere_mesh_generator_top
  import usg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  in_slice_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_pos_z,
  output logic [15:0] out_norm_x,
  output logic [15:0] out_norm_y,
  output logic [15:0] out_norm_z,
  output logic        out_tri_valid,
  output logic [23:0] out_tri_a,
  output logic [23:0] out_tri_b,
  output logic [23:0] out_tri_c,
  output logic        out_last
);

  logic [30:0] radius_r;
  logic [10:0] slices_r;
  logic [5:0]  stacks_r;
  logic [31:0] cx_r, cy_r, cz_r;
  logic [23:0] ibase_r;
  logic        wr_en;
  logic [2:0]  reg_idx;
  usg_cfg_t    cfg;

  logic       q_push, q_pop, q_not_empty, q_full;
  logic [9:0] q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 31'd65536;
      slices_r <= 11'd16;
      stacks_r <= 6'd8;
      cx_r     <= '0;
      cy_r     <= '0;
      cz_r     <= '0;
      ibase_r  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RADIUS: radius_r <= pwdata[30:0];
        REG_SLICES: slices_r <= pwdata[10:0];
        REG_STACKS: stacks_r <= pwdata[5:0];
        REG_CX:     cx_r     <= pwdata;
        REG_CY:     cy_r     <= pwdata;
        REG_CZ:     cz_r     <= pwdata;
        REG_IBASE:  ibase_r  <= pwdata[23:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIUS: prdata = {1'b0, radius_r};
      REG_SLICES: prdata = {21'b0, slices_r};
      REG_STACKS: prdata = {26'b0, stacks_r};
      REG_CX:     prdata = cx_r;
      REG_CY:     prdata = cy_r;
      REG_CZ:     prdata = cz_r;
      REG_IBASE:  prdata = {8'b0, ibase_r};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.radius     = radius_r;
    cfg.slices     = clamp_slices(slices_r);
    cfg.stacks     = clamp_stacks(stacks_r);
    cfg.cx         = $signed(cx_r);
    cfg.cy         = $signed(cy_r);
    cfg.cz         = $signed(cz_r);
    cfg.index_base = ibase_r;
  end

  usg_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_slice_number (in_slice_number),
    .slices          (cfg.slices),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_wdata)
  );

  usg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  usg_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_valid       (q_not_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_pos_z     (out_pos_z),
    .out_norm_x    (out_norm_x),
    .out_norm_y    (out_norm_y),
    .out_norm_z    (out_norm_z),
    .out_tri_valid (out_tri_valid),
    .out_tri_a     (out_tri_a),
    .out_tri_b     (out_tri_b),
    .out_tri_c     (out_tri_c),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

[test/testbench.sv]
// Testbench for the UV sphere mesh generator: directed table, then random slices per phase.
`timescale 1ns / 1ps

module testbench
  import usg_pkg::*;
();

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int DRAIN_WAIT  = 400;

  typedef struct {
    logic [31:0] px, py, pz;
    logic [15:0] nx, ny, nz;
    logic        tv;
    logic [23:0] ta, tb, tc;
    logic        lst;
  } vertex_t;

  typedef struct {
    logic        is_cfg;
    logic [2:0]  idx;
    logic [31:0] val;
    logic [9:0]  slice;
    logic        chk;
    logic [31:0] pole_y;
  } row_t;

  localparam longint unsigned SIN_DIV [5] = '{110, 72, 42, 20, 6};
  localparam longint unsigned COS_DIV [6] = '{132, 90, 56, 30, 12, 2};
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned PI30    = 64'd3373259426;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_ready;
  logic [9:0]  in_slice_number = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic [15:0] out_norm_x, out_norm_y, out_norm_z;
  logic        out_tri_valid;
  logic [23:0] out_tri_a, out_tri_b, out_tri_c;
  logic        out_last;

  // mirrored registers and vertex counter
  logic [30:0] m_radius;
  logic [10:0] m_slices;
  logic [5:0]  m_stacks;
  logic [31:0] m_cx, m_cy, m_cz;
  logic [23:0] m_ibase;
  logic [23:0] m_vcount;

  vertex_t pending_vertices[$];
  int      errors = 0;
  int      cycles = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_cycles = 0;

  uv_sphere_mesh_generator_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("uv_sphere_mesh_generator_top: mismatch");
      $finish;
    end
  end

  function automatic longint round_shift(longint v, int sh);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic void taylor(longint unsigned x, output longint unsigned s,
                                 output longint unsigned c);
    longint unsigned x2, t;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t = ONE_Q30;
    for (int k = 0; k < 5; k++) t = ONE_Q30 - (((x2 * t) >> 30) / SIN_DIV[k]);
    s = (x * t) >> 30;
    t = ONE_Q30;
    for (int k = 0; k < 6; k++) t = ONE_Q30 - (((x2 * t) >> 30) / COS_DIV[k]);
    c = t;
  endfunction

  // sin/cos of a 32-bit turn fraction, Q30; folded to the first octant
  function automatic void turn_sincos(logic [31:0] ph, output longint s, output longint c);
    longint unsigned f, x, ps, pc;
    longint sa, ca;
    f = ph[29:0];
    if (f <= (64'd1 << 29)) begin
      x = (f * PI30 + (64'd1 << 30)) >> 31;
      taylor(x, ps, pc);
      sa = ps; ca = pc;
    end else begin
      x = (((64'd1 << 30) - f) * PI30 + (64'd1 << 30)) >> 31;
      taylor(x, ps, pc);
      sa = pc; ca = ps;
    end
    case (ph[31:30])
      2'd0: begin s = sa;  c = ca;  end
      2'd1: begin s = ca;  c = -sa; end
      2'd2: begin s = -sa; c = -ca; end
      default: begin s = -ca; c = sa; end
    endcase
  endfunction

  function automatic vertex_t place_vertex(longint nx, longint ny, longint nz);
    vertex_t v;
    longint r;
    r = m_radius;
    v.px = clip32(longint'($signed(m_cx)) + round_shift(r * nx, 30));
    v.py = clip32(longint'($signed(m_cy)) + round_shift(r * ny, 30));
    v.pz = clip32(longint'($signed(m_cz)) + round_shift(r * nz, 30));
    v.nx = 16'(round_shift(nx, 16));
    v.ny = 16'(round_shift(ny, 16));
    v.nz = 16'(round_shift(nz, 16));
    return v;
  endfunction

  function automatic int eff_slices();
    return (m_slices == 0) ? 1 : (m_slices > MAX_SLICES) ? MAX_SLICES : m_slices;
  endfunction

  // queue every vertex/triangle the slice produces
  function automatic void tessellate_slice(logic [9:0] slice);
    longint unsigned slc, stk, i;
    longint s0, c0, s1, c1, sl, cl;
    vertex_t v[$];
    vertex_t t;
    logic [23:0] base;
    int nres;
    slc = eff_slices();
    stk = (m_stacks < 2) ? 2 : (m_stacks > MAX_STACKS) ? MAX_STACKS : m_stacks;
    i = slice;
    if (i >= slc) return;
    nres = 2 * stk;
    turn_sincos(32'((i << 32) / slc), s0, c0);
    turn_sincos(32'(((i + 1) << 32) / slc), s1, c1);
    v = {v, place_vertex(0, -longint'(ONE_Q30), 0)};
    for (longint unsigned j = 1; j < stk; j++) begin
      turn_sincos(32'((j << 31) / stk), sl, cl);
      v = {v, place_vertex(round_shift(sl * s0, 30), -cl, round_shift(sl * c0, 30))};
      v = {v, place_vertex(round_shift(sl * s1, 30), -cl, round_shift(sl * c1, 30))};
    end
    v = {v, place_vertex(0, longint'(ONE_Q30), 0)};
    base = m_ibase + m_vcount;
    for (int k = 0; k < nres; k++) begin
      t = v[k];
      t.tv = (k >= 2);
      t.ta = (k >= 2) ? base + 24'(k - 2) : '0;
      t.tb = (k < 2) ? '0 : (k % 2) ? base + 24'(k - 1) : base + 24'(k);
      t.tc = (k < 2) ? '0 : (k % 2) ? base + 24'(k) : base + 24'(k - 1);
      t.lst = (k == nres - 1);
      pending_vertices = {pending_vertices, t};
    end
    m_vcount = m_vcount + 24'(nres);
  endfunction

  function automatic void cmp(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", name, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = pending_vertices.pop_front();
        cmp("pos_x", e.px, out_pos_x);
        cmp("pos_y", e.py, out_pos_y);
        cmp("pos_z", e.pz, out_pos_z);
        cmp("norm_x", e.nx, out_norm_x);
        cmp("norm_y", e.ny, out_norm_y);
        cmp("norm_z", e.nz, out_norm_z);
        cmp("tri_valid", e.tv, out_tri_valid);
        cmp("tri_a", e.ta, out_tri_a);
        cmp("tri_b", e.tb, out_tri_b);
        cmp("tri_c", e.tc, out_tri_c);
        cmp("last", e.lst, out_last);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_RADIUS: m_radius = val[30:0];
      REG_SLICES: m_slices = val[10:0];
      REG_STACKS: m_stacks = val[5:0];
      REG_CX:     m_cx = val;
      REG_CY:     m_cy = val;
      REG_CZ:     m_cz = val;
      REG_IBASE:  m_ibase = val[23:0];
      default: ;
    endcase
  endtask

  // in_valid stays high across back-to-back transactions
  task automatic send_slice(logic [9:0] slice);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_slice_number <= slice;
    do @(posedge clk); while (!in_ready);
    tessellate_slice(slice);
  endtask

  task automatic random_config();
    int r;
    r = $urandom_range(99);
    reg_write(REG_RADIUS, (r < 70) ? $urandom_range(0, 1 << 24) : $urandom);
    r = $urandom_range(99);
    reg_write(REG_SLICES, (r < 60) ? $urandom_range(1, 40) :
                          (r < 80) ? $urandom_range(1, MAX_SLICES) : $urandom_range(0, 2047));
    r = $urandom_range(99);
    reg_write(REG_STACKS, (r < 80) ? $urandom_range(2, 6) :
                          (r < 88) ? MAX_STACKS : $urandom_range(0, 63));
    for (int k = 0; k < 3; k++) begin
      r = $urandom_range(99);
      reg_write(3'(REG_CX + k), (r < 75) ? 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24))
                                         : $urandom);
    end
    r = $urandom_range(99);
    reg_write(REG_IBASE, (r < 30) ? 24'hFFFFFF - $urandom_range(0, 40) : $urandom);
  endtask

  row_t directed [24] = '{
    '{0, 0, 0, 10'd0, 1, 32'hFFFF_0000},
    '{0, 0, 0, 10'd15, 0, 0},
    '{0, 0, 0, 10'd16, 0, 0},                // beyond slice count: nothing
    '{1, REG_STACKS, 32'd0, 0, 0, 0},         // clamps up to 2
    '{0, 0, 0, 10'd0, 0, 0},
    '{1, REG_STACKS, 32'd63, 0, 0, 0},        // clamps down to 32
    '{0, 0, 0, 10'd1, 0, 0},
    '{1, REG_SLICES, 32'd0, 0, 0, 0},         // counts as one slice
    '{0, 0, 0, 10'd0, 0, 0},
    '{0, 0, 0, 10'd1, 0, 0},
    '{1, REG_SLICES, 32'd2047, 0, 0, 0},      // counts as the maximum
    '{0, 0, 0, 10'd1023, 0, 0},
    '{1, REG_RADIUS, 32'hFFFF_FFFF, 0, 0, 0},
    '{1, REG_CX, 32'h7FFF_FFFF, 0, 0, 0},
    '{1, REG_CY, 32'h8000_0000, 0, 0, 0},
    '{1, REG_CZ, 32'hFFFF_0000, 0, 0, 0},
    '{1, REG_STACKS, 32'd2, 0, 0, 0},
    '{0, 0, 0, 10'd0, 1, 32'h8000_0000},      // saturated bottom pole
    '{1, REG_IBASE, 32'hFFFF_FFFF, 0, 0, 0},  // indices wrap
    '{0, 0, 0, 10'd512, 0, 0},
    '{1, REG_SLICES, 32'd3, 0, 0, 0},
    '{1, REG_STACKS, 32'd5, 0, 0, 0},
    '{0, 0, 0, 10'd2, 0, 0},
    '{0, 0, 0, 10'd1, 0, 0}
  };

  initial begin
    int before_cnt, done, slice;
    int idle_pcts[4] = '{0, 57, 0, 31};
    int stall_pcts[4] = '{0, 0, 57, 31};
    m_radius = 31'd65536; m_slices = 11'd16; m_stacks = 6'd8;
    m_cx = '0; m_cy = '0; m_cz = '0; m_ibase = '0; m_vcount = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    repeat (2) @(posedge clk);

    foreach (directed[n]) begin
      if (directed[n].is_cfg) begin
        wait_idle();
        reg_write(directed[n].idx, directed[n].val);
      end else begin
        before_cnt = pending_vertices.size();
        send_slice(directed[n].slice);
        if (directed[n].chk && pending_vertices[before_cnt].py !== directed[n].pole_y) begin
          $error("pole pos_y: expected %h, predicted %h", directed[n].pole_y,
                 pending_vertices[before_cnt].py);
          errors++;
        end
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      random_config();
      send_idle_pct = idle_pcts[ph];
      recv_stall_pct = stall_pcts[ph];
      done = 0;
      while (done < 62) begin
        if (ph == 0 && done == 30) begin
          // let the block drain completely
          in_valid <= 0;
          @(posedge clk);
          while (pending_vertices.size() != 0) @(posedge clk);
        end
        if (ph == 1 && done == 20) hold_cycles = 3000;
        slice = ($urandom_range(99) < 85) ? $urandom_range(0, eff_slices() - 1)
                                          : $urandom_range(0, 1023);
        if (slice < eff_slices()) done++;
        send_slice(10'(slice));
      end
    end

    in_valid <= 0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) $display("uv_sphere_mesh_generator_top: match");
    else $display("uv_sphere_mesh_generator_top: mismatch");
    $finish;
  end

endmodule
